FILE: rtl/afm_pkg.sv
package afm_pkg;

  // table size
  localparam int DEFAULT_RULE_COUNT = 16;
  localparam int SLOT_W = 4;

  // operation codes (carried on s_tuser)
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  // match kinds
  localparam logic [2:0] KIND_ANY    = 3'd0;
  localparam logic [2:0] KIND_SINGLE = 3'd1;
  localparam logic [2:0] KIND_MASK   = 3'd2;
  localparam logic [2:0] KIND_SUBNET = 3'd3;
  localparam logic [2:0] KIND_RANGE  = 3'd4;

  // longest legal subnet prefix per family
  localparam logic [7:0] V4_PREFIX_MAX = 8'd32;
  localparam logic [7:0] V6_PREFIX_MAX = 8'd128;

  localparam int IN_DATA_W  = 288;
  localparam int OUT_DATA_W = 8;

  // input transfer payload, last member in the lowest bits
  typedef struct packed {
    logic [63:0]       bound_low;
    logic [63:0]       bound_high;
    logic [63:0]       addr_low;
    logic [63:0]       addr_high;
    logic [7:0]        prefix_len;
    logic [15:0]       port_number;
    logic [2:0]        match_kind;
    logic              is_v6;
    logic [SLOT_W-1:0] rule_slot;
  } in_item_t;

  // result transfer payload
  typedef struct packed {
    logic [1:0]        pad;
    logic [SLOT_W-1:0] match_slot;
    logic              matched;
    logic              status;
  } out_item_t;

  // one stored rule; IPv4 rules hold zeros above bit 31
  typedef struct packed {
    logic         is_v6;
    logic [2:0]   kind;
    logic [15:0]  port;
    logic [127:0] addr;
    logic [127:0] bound;
  } rule_entry_t;

endpackage

FILE: rtl/acl_first_match_filter.sv
// acl_first_match_filter: first-match access rule table with a sequential scan.
// Write transfer: result registered in the cycle after acceptance; writes can go every
//   cycle while no result is stalled. Lookup transfer: one rule per cycle from slot 0,
//   stops at the first hit; a range rule passing its lower check adds an ST_RANGE step.
//   The shared 128-bit magnitude comparator and the one-read rule memory set this pace.
// Reset (rst, synchronous, active high) clears all valid bits, the sequencer and m_tvalid.
module acl_first_match_filter #(
  parameter int RULE_COUNT = afm_pkg::DEFAULT_RULE_COUNT
) (
  input  logic                            clk,
  input  logic                            rst,
  // s_tdata, low bit up: rule_slot[4], is_v6[1], match_kind[3], port_number[16],
  //   prefix_len[8], addr_high[64], addr_low[64], bound_high[64], bound_low[64]
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [afm_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                            s_tuser,   // opcode: 0 lookup, 1 write rule
  // m_tdata, low bit up: status[1], matched[1], match_slot[4], zero pad[2]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [afm_pkg::OUT_DATA_W-1:0]  m_tdata
);

  localparam int IDX_W = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RULE_COUNT - 1);

  // scan sequencer
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,  // entry at idx is in rd_entry: family, port, kind checks
    ST_RANGE = 3'b100   // range rule: upper bound compare on the shared comparator
  } state_t;

  state_t state, state_next;
  logic [IDX_W-1:0] idx, idx_next;

  afm_pkg::in_item_t    item;
  afm_pkg::rule_entry_t new_entry;
  afm_pkg::rule_entry_t rd_entry;
  afm_pkg::rule_entry_t rule_mem [RULE_COUNT];
  afm_pkg::out_item_t   result;

  logic [RULE_COUNT-1:0] slot_valid;

  // latched query
  logic         q_v6;
  logic [15:0]  q_port;
  logic [127:0] q_addr;

  logic         in_accept;
  logic         prefix_bad;
  logic         slot_in_range;
  logic         mem_we;
  logic [127:0] in_addr;
  logic [127:0] in_bound;
  logic [127:0] subnet_mask;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;

  logic [127:0] cmp_a, cmp_b;
  logic         cmp_le;

  logic             out_load;
  logic             out_status;
  logic             out_matched;
  logic [IDX_W-1:0] out_slot;

  logic family_ok;
  logic step_hit;
  logic step_miss;

  assign item      = s_tdata;
  assign s_tready  = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign in_accept = s_tvalid && s_tready;

  // ---------------------------------------------------------------- write path
  // Addresses of IPv4 items are cut to 32 bits on the way in, so the scan
  // compares one 128-bit format for both families.
  assign in_addr = item.is_v6 ? {item.addr_high, item.addr_low}
                              : {96'd0, item.addr_low[31:0]};

  always_comb begin
    if (item.is_v6) begin
      subnet_mask = ~({128{1'b1}} >> item.prefix_len);
    end else begin
      subnet_mask = {96'd0, ~(32'hffff_ffff >> item.prefix_len)};
    end
  end

  always_comb begin
    if (item.match_kind == afm_pkg::KIND_SUBNET) begin
      in_bound = subnet_mask;
    end else if (item.is_v6) begin
      in_bound = {item.bound_high, item.bound_low};
    end else begin
      in_bound = {96'd0, item.bound_low[31:0]};
    end
  end

  assign prefix_bad = (item.match_kind == afm_pkg::KIND_SUBNET) &&
                      (item.prefix_len > (item.is_v6 ? afm_pkg::V6_PREFIX_MAX
                                                     : afm_pkg::V4_PREFIX_MAX));
  assign slot_in_range = (32'(item.rule_slot) < RULE_COUNT);
  assign mem_we = in_accept && (s_tuser == afm_pkg::OP_WRITE) && !prefix_bad &&
                  slot_in_range;

  assign new_entry.is_v6 = item.is_v6;
  assign new_entry.kind  = item.match_kind;
  assign new_entry.port  = item.port_number;
  assign new_entry.addr  = in_addr;
  assign new_entry.bound = in_bound;

  // rule memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      rule_mem[IDX_W'(item.rule_slot)] <= new_entry;
    end
    if (rd_en) begin
      rd_entry <= rule_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (mem_we) begin
      slot_valid[IDX_W'(item.rule_slot)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && (s_tuser == afm_pkg::OP_LOOKUP)) begin
      q_v6   <= item.is_v6;
      q_port <= item.port_number;
      q_addr <= in_addr;
    end
  end

  // ---------------------------------------------------------- shared compare
  // lower check (rule addr <= query) in ST_CHECK, upper (query <= bound) in ST_RANGE
  assign cmp_a  = (state == ST_RANGE) ? q_addr : rd_entry.addr;
  assign cmp_b  = (state == ST_RANGE) ? rd_entry.bound : q_addr;
  assign cmp_le = (cmp_a <= cmp_b);

  assign family_ok = (rd_entry.is_v6 == q_v6) &&
                     ((rd_entry.port == 16'd0) || (rd_entry.port == q_port));

  // --------------------------------------------------------------- sequencer
  always_comb begin
    state_next  = state;
    idx_next    = idx;
    rd_en       = 1'b0;
    rd_addr     = idx + 1'b1;
    out_load    = 1'b0;
    out_status  = 1'b0;
    out_matched = 1'b0;
    out_slot    = '0;
    step_hit    = 1'b0;
    step_miss   = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (s_tuser == afm_pkg::OP_WRITE) begin
            out_load   = 1'b1;
            out_status = prefix_bad;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = '0;
            idx_next   = '0;
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (!slot_valid[idx]) begin
          step_miss = 1'b1;
        end else if (rd_entry.kind == afm_pkg::KIND_ANY) begin
          step_hit = 1'b1;
        end else if (!family_ok) begin
          step_miss = 1'b1;
        end else begin
          case (rd_entry.kind)
            afm_pkg::KIND_MASK, afm_pkg::KIND_SUBNET: begin
              step_hit  = (((rd_entry.addr ^ q_addr) & rd_entry.bound) == 128'd0);
              step_miss = !step_hit;
            end
            afm_pkg::KIND_RANGE: begin
              step_miss = !cmp_le;
              if (cmp_le) begin
                state_next = ST_RANGE;
              end
            end
            default: begin  // single, and unknown kinds
              step_hit  = (rd_entry.addr == q_addr);
              step_miss = !step_hit;
            end
          endcase
        end
      end
      ST_RANGE: begin
        step_hit  = cmp_le;
        step_miss = !cmp_le;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (step_hit) begin
      out_load    = 1'b1;
      out_matched = 1'b1;
      out_slot    = idx;
      state_next  = ST_IDLE;
    end else if (step_miss) begin
      if (idx == LAST_IDX) begin
        out_load   = 1'b1;
        state_next = ST_IDLE;
      end else begin
        // prefetch the next entry while this one is retired
        rd_en      = 1'b1;
        idx_next   = idx + 1'b1;
        state_next = ST_CHECK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // ------------------------------------------------------------ result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.pad        <= 2'b00;
      result.match_slot <= afm_pkg::SLOT_W'(out_slot);  // low 4 bits of the index
      result.matched    <= out_matched;
      result.status     <= out_status;
    end
  end

  assign m_tdata = result;

endmodule

FILE: rtl/afm_checker.sv
module afm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [afm_pkg::OUT_DATA_W-1:0] m_tdata
);

  afm_pkg::out_item_t res;
  logic               in_xfer;

  assign res     = m_tdata;
  assign in_xfer = s_tvalid && s_tready;

  // no new item while a result is stuck at the output
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while result stalled");

  // a rule write answers in the next cycle
  a_write_result: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (s_tuser == afm_pkg::OP_WRITE) |=> m_tvalid)
    else $error("write result missing");

  // a lookup occupies the scan, so input closes
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (s_tuser == afm_pkg::OP_LOOKUP) |=> !s_tready)
    else $error("input open during lookup scan");

  // error status never comes with a match, no-match slot is zero
  a_result_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(res.status && res.matched) && (res.matched || res.match_slot == '0))
    else $error("inconsistent result fields");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind acl_first_match_filter afm_checker u_afm_checker (.*);

FILE: test/tb_acl_first_match_filter.sv
`timescale 1ns / 100ps

module tb_acl_first_match_filter;

  localparam int RULE_COUNT = afm_pkg::DEFAULT_RULE_COUNT;
  // match kinds with no name of their own; the block treats them as single
  localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [afm_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                           s_tuser = afm_pkg::OP_LOOKUP;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [afm_pkg::OUT_DATA_W-1:0] m_tdata;

  acl_first_match_filter u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  // shadow rule table, addresses held at family width
  bit           rule_valid [RULE_COUNT];
  logic         rule_v6    [RULE_COUNT];
  logic [2:0]   rule_kind  [RULE_COUNT];
  logic [15:0]  rule_port  [RULE_COUNT];
  logic [127:0] rule_addr  [RULE_COUNT];
  logic [127:0] rule_bound [RULE_COUNT];

  afm_pkg::out_item_t pending_verdicts [$];
  int                 err_count = 0;
  bit                 tx_gaps = 1'b1;
  bit                 rx_gaps = 1'b1;
  int                 hold_req = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [127:0] rand128();
    return {rand64(), rand64()};
  endfunction

  // IPv4 uses only the low 32 bits of the low half
  function automatic logic [127:0] family_addr(logic v6, logic [63:0] hi, logic [63:0] lo);
    return v6 ? {hi, lo} : {96'h0, lo[31:0]};
  endfunction

  function automatic bit rule_hits(int s, logic v6, logic [15:0] port, logic [127:0] q);
    logic [127:0] a, b;
    a = rule_addr[s];
    b = rule_bound[s];
    if (rule_kind[s] == afm_pkg::KIND_ANY) return 1'b1;
    if (rule_v6[s] != v6) return 1'b0;
    if (rule_port[s] != 16'h0 && rule_port[s] != port) return 1'b0;
    case (rule_kind[s])
      afm_pkg::KIND_MASK, afm_pkg::KIND_SUBNET: return (a & b) == (q & b);
      afm_pkg::KIND_RANGE: return (a <= q) && (q <= b);
      default: return a == q;
    endcase
  endfunction

  // updates the shadow table on writes, scans it on lookups
  function automatic afm_pkg::out_item_t predict_verdict(logic op, afm_pkg::in_item_t it);
    afm_pkg::out_item_t v;
    logic [127:0]       b, q;
    logic [31:0]        m32;
    logic [7:0]         lim;
    v = '0;
    if (op == afm_pkg::OP_WRITE) begin
      b = family_addr(it.is_v6, it.bound_high, it.bound_low);
      if (it.match_kind == afm_pkg::KIND_SUBNET) begin
        lim = it.is_v6 ? afm_pkg::V6_PREFIX_MAX : afm_pkg::V4_PREFIX_MAX;
        if (it.prefix_len > lim) begin
          v.status = 1'b1;
          return v;
        end
        if (it.is_v6) begin
          b = ~128'h0 << (8'd128 - it.prefix_len);
        end else begin
          m32 = ~32'h0 << (6'd32 - it.prefix_len[5:0]);
          b = {96'h0, m32};
        end
      end
      rule_valid[it.rule_slot] = 1'b1;
      rule_v6[it.rule_slot]    = it.is_v6;
      rule_kind[it.rule_slot]  = it.match_kind;
      rule_port[it.rule_slot]  = it.port_number;
      rule_addr[it.rule_slot]  = family_addr(it.is_v6, it.addr_high, it.addr_low);
      rule_bound[it.rule_slot] = b;
    end else begin
      q = family_addr(it.is_v6, it.addr_high, it.addr_low);
      for (int s = 0; s < RULE_COUNT; s++) begin
        if (rule_valid[s] && rule_hits(s, it.is_v6, it.port_number, q)) begin
          v.matched = 1'b1;
          v.match_slot = afm_pkg::SLOT_W'(s);
          break;
        end
      end
    end
    return v;
  endfunction

  // offer one item, hold it until the transfer, then maybe pause
  task automatic send_item(input logic op, input afm_pkg::in_item_t it);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= it;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_verdicts.push_back(predict_verdict(op, it));
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic write_rule(input logic [3:0] slot, input logic v6, input logic [2:0] kind,
                            input logic [15:0] port, input logic [7:0] plen,
                            input logic [127:0] a, input logic [127:0] b);
    afm_pkg::in_item_t it;
    it.rule_slot   = slot;
    it.is_v6       = v6;
    it.match_kind  = kind;
    it.port_number = port;
    it.prefix_len  = plen;
    it.addr_high   = a[127:64];
    it.addr_low    = a[63:0];
    it.bound_high  = b[127:64];
    it.bound_low   = b[63:0];
    send_item(afm_pkg::OP_WRITE, it);
  endtask

  // fields a lookup ignores get random content; IPv4 gets junk above bit 31
  task automatic lookup(input logic v6, input logic [15:0] port, input logic [127:0] q);
    afm_pkg::in_item_t it;
    logic [127:0]      junk;
    junk = rand128();
    it.rule_slot   = 4'($urandom());
    it.is_v6       = v6;
    it.match_kind  = 3'($urandom());
    it.port_number = port;
    it.prefix_len  = 8'($urandom());
    it.addr_high   = v6 ? q[127:64] : junk[127:64];
    it.addr_low    = v6 ? q[63:0] : {junk[63:32], q[31:0]};
    it.bound_high  = rand64();
    it.bound_low   = rand64();
    send_item(afm_pkg::OP_LOOKUP, it);
  endtask

  task automatic write_random_rule(input logic [3:0] slot);
    logic         v6;
    logic [2:0]   kind;
    logic [15:0]  port;
    logic [7:0]   plen;
    logic [127:0] a, b, d;
    int           r;
    v6   = 1'($urandom());
    port = ($urandom_range(0, 2) == 0) ? 16'h0 : 16'($urandom());
    plen = 8'($urandom());
    a    = rand128();
    b    = rand128();
    r    = $urandom_range(0, 99);
    if (r < 4) kind = afm_pkg::KIND_ANY;
    else if (r < 24) kind = afm_pkg::KIND_SINGLE;
    else if (r < 44) kind = afm_pkg::KIND_MASK;
    else if (r < 70) kind = afm_pkg::KIND_SUBNET;
    else if (r < 92) kind = afm_pkg::KIND_RANGE;
    else kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
    // mostly legal prefixes, now and then anything up to 255
    if (kind == afm_pkg::KIND_SUBNET && $urandom_range(0, 9) != 0)
      plen = 8'($urandom_range(0, v6 ? 128 : 32));
    if (kind == afm_pkg::KIND_RANGE) begin
      case ($urandom_range(0, 3))
        0: d = 128'($urandom_range(0, 64));
        1: begin
          // low half near its top so the bound carries into the high half
          a[63:32] = '1;
          d = {96'h0, $urandom()};
        end
        2: d = rand128() >> $urandom_range(0, 127);
        default: d = rand128();
      endcase
      b = a + d;
    end
    write_rule(slot, v6, kind, port, plen, a, b);
  endtask

  // lookup aimed at one stored rule, hit or near miss
  task automatic lookup_near_rule(input int s);
    logic         v6;
    logic [15:0]  port;
    logic [127:0] q, lo, hi, span;
    v6   = rule_v6[s];
    port = (rule_port[s] == 16'h0 || $urandom_range(0, 9) == 0) ? 16'($urandom()) : rule_port[s];
    lo   = rule_addr[s];
    hi   = rule_bound[s];
    case (rule_kind[s])
      afm_pkg::KIND_ANY: begin
        v6 = 1'($urandom());
        q  = rand128();
      end
      afm_pkg::KIND_MASK, afm_pkg::KIND_SUBNET: q = (lo & hi) | (rand128() & ~hi);
      afm_pkg::KIND_RANGE: begin
        case ($urandom_range(0, 4))
          0: q = lo;
          1: q = hi;
          2: q = lo - 1;
          3: q = hi + 1;
          default: begin
            span = hi - lo + 1;
            q = (lo <= hi && span != 0) ? lo + rand128() % span : rand128();
          end
        endcase
      end
      default: q = lo;
    endcase
    if ($urandom_range(0, 9) == 0)
      q[v6 ? $urandom_range(0, 127) : $urandom_range(0, 31)] ^= 1'b1;
    lookup(v6, port, q);
  endtask

  task automatic send_random_items(input int n);
    int s;
    for (int i = 0; i < n; i++) begin
      s = $urandom_range(0, RULE_COUNT - 1);
      if ($urandom_range(0, 99) < 35)
        write_random_rule(4'(s));
      else if ($urandom_range(0, 4) != 0 && rule_valid[s])
        lookup_near_rule(s);
      else
        lookup(1'($urandom()), 16'($urandom()), rand128());
    end
  endtask

  // nothing stored yet: no lookup may match
  task automatic test_empty_table();
    lookup(1'b0, 16'h0, 128'h0);
    lookup(1'b1, 16'hffff, '1);
  endtask

  task automatic test_directed_rules();
    // single with extreme port, junk above the IPv4 address
    write_rule(4'd0, 1'b0, afm_pkg::KIND_SINGLE, 16'hffff, 8'd0,
               {64'hffff_ffff_ffff_ffff, 64'habcd_0123_c0a8_0001}, '0);
    lookup(1'b0, 16'hffff, 128'hc0a8_0001);
    lookup(1'b0, 16'hfffe, 128'hc0a8_0001);
    // prefixes too long for the family are refused
    write_rule(4'd1, 1'b0, afm_pkg::KIND_SUBNET, 16'h0, afm_pkg::V4_PREFIX_MAX + 8'd1,
               rand128(), rand128());
    write_rule(4'd1, 1'b1, afm_pkg::KIND_SUBNET, 16'h0, afm_pkg::V6_PREFIX_MAX + 8'd1,
               rand128(), rand128());
    write_rule(4'd1, 1'b1, afm_pkg::KIND_SUBNET, 16'h0, 8'hff, rand128(), rand128());
    // full-length and zero-length prefixes
    write_rule(4'd2, 1'b0, afm_pkg::KIND_SUBNET, 16'h0, afm_pkg::V4_PREFIX_MAX,
               128'h0a00_0001, '1);
    write_rule(4'd3, 1'b1, afm_pkg::KIND_SUBNET, 16'd53, afm_pkg::V6_PREFIX_MAX,
               {64'h2001_0db8_0000_0000, 64'h1}, '0);
    write_rule(4'd13, 1'b1, afm_pkg::KIND_SUBNET, 16'h0, 8'd0, rand128(), rand128());
    // range spanning the 64-bit boundary: a word-wise compare gets this wrong
    write_rule(4'd4, 1'b1, afm_pkg::KIND_RANGE, 16'h0, 8'd0,
               {64'h1, 64'hffff_ffff_ffff_fff0}, {64'h2, 64'h10});
    write_rule(4'd5, 1'b0, afm_pkg::KIND_MASK, 16'h0, 8'd0, 128'h0a0b_0000,
               {96'hffff_ffff_ffff_ffff_ffff_ffff, 32'hffff_0000});
    write_rule(4'd6, 1'b0, KIND_SPARE_LAST, 16'd1, 8'd0, 128'hdead_beef, '0);
    write_rule(4'd7, 1'b0, afm_pkg::KIND_RANGE, 16'h0, 8'd0, 128'hffff_fff0, 128'hffff_ffff);
    write_rule(4'd15, 1'b0, afm_pkg::KIND_ANY, 16'd7, 8'd0, '0, '0);
    lookup(1'b0, 16'h0, 128'h0a00_0001);
    lookup(1'b1, 16'd53, {64'h2001_0db8_0000_0000, 64'h1});
    lookup(1'b1, 16'd54, {64'h2001_0db8_0000_0000, 64'h1});
    lookup(1'b1, 16'h0, {64'h2, 64'h0});
    lookup(1'b1, 16'h0, {64'h2, 64'h11});
    lookup(1'b0, 16'd9, 128'h0a0b_1234);
    lookup(1'b0, 16'd1, 128'hdead_beef);
    lookup(1'b0, 16'd1, 128'hffff_ffff);
    lookup(1'b0, 16'd2, 128'h0102_0304);
  endtask

  task automatic test_random_traffic();
    send_random_items(550);
  endtask

  // result side held off while items keep coming: input must stall
  task automatic test_input_stall();
    tx_gaps  = 1'b0;
    hold_req = 80;
    send_random_items(40);
    tx_gaps  = 1'b1;
  endtask

  task automatic test_steady_stream();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    send_random_items(150);
  endtask

  // result side: random stall bursts, one long hold on request
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  afm_pkg::out_item_t got, want;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_verdicts.size() == 0) begin
        $error("result transfer with nothing expected: %h", m_tdata);
        err_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          err_count++;
        end
        if (got.matched !== want.matched) begin
          $error("matched: expected %0d, got %0d", want.matched, got.matched);
          err_count++;
        end
        if (got.match_slot !== want.match_slot) begin
          $error("match_slot: expected %0d, got %0d", want.match_slot, got.match_slot);
          err_count++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_directed_rules();
    test_random_traffic();
    test_input_stall();
    test_steady_stream();
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    // a stray late result would show up within one full scan
    repeat (2 * RULE_COUNT + 8) @(posedge clk);
    if (err_count == 0)
      $display("acl_first_match_filter verification clean");
    else
      $display("acl_first_match_filter verification failed");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("acl_first_match_filter verification failed");
    $finish;
  end

endmodule
